// ===== design/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial line editor package
// Shared constants, request kind codes and the decoded item record that is
// handed from the request decoder to the response sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

   // Default line buffer size; the line holds one character fewer.
   localparam int BUFFER_DEPTH_DEF = 64;

   // Request kind codes.
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_RX   = 2'd0;
   localparam kind_type KIND_TAKE = 2'd1;
   localparam kind_type KIND_READ = 2'd2;

   // Response kind codes.
   localparam logic RES_TX   = 1'b0;
   localparam logic RES_READ = 1'b1;

   // Terminal control characters.
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_GT  = 8'h3E;

   // One decoded request: up to three transmit bytes, or one read answer.
   typedef struct packed {
      logic       is_read;
      logic       in_range;
      logic [1:0] last_idx;
      logic [7:0] tx0;
      logic [7:0] tx1;
      logic [7:0] tx2;
      logic [5:0] line_length;
      logic       line_ready;
   } item_type;

endpackage

`default_nettype wire

// ===== design/sle_req_if.sv =====
// ----------------------------------------------------------------------------
// Serial line editor request channel
// Valid/ready channel carrying one editor request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] rx_byte;
   logic [5:0] read_index;

   modport source (output valid, output kind, output rx_byte, output read_index,
                   input ready);
   modport sink (input valid, input kind, input rx_byte, input read_index,
                 output ready);
endinterface

`default_nettype wire

// ===== design/sle_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Serial line editor response channel
// Valid/ready channel carrying one transmit byte or one read answer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] tx_byte;
   logic [7:0] read_char;
   logic [5:0] line_length;
   logic       line_ready;
   logic       last;

   modport source (output valid, output result_kind, output tx_byte, output read_char,
                   output line_length, output line_ready, output last, input ready);
   modport sink (input valid, input result_kind, input tx_byte, input read_char,
                 input line_length, input line_ready, input last, output ready);
endinterface

`default_nettype wire

// ===== design/serial_line_editor_echo_unit.sv =====
// ----------------------------------------------------------------------------
// Serial line editor with echo, top level
// Decodes requests, keeps the fill count and pending flag, owns the line
// store and feeds the response sequencer.
// ----------------------------------------------------------------------------
// Path: request -> sequencer holding stage -> registered output stage.
// Throughput: one response per cycle unless the response channel stalls;
//   one-response requests go back to back.
// Reset: synchronous, clears the fill count, pending flag and all valids;
//   the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_editor_echo_unit
   import sle_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   sle_req_if.sink   req_ch,
   sle_rsp_if.source rsp_ch
);

   localparam int CW   = $clog2(BUFFER_DEPTH);
   localparam int CMPW = (CW > 6) ? CW : 6;
   localparam logic [CW-1:0] FILL_MAX = CW'(BUFFER_DEPTH - 1);

   logic [CW-1:0]   fill_ff, fill_in;
   logic            pending_ff, pending_in;
   logic [CMPW-1:0] fill_ext;
   logic [CMPW-1:0] idx_ext;
   logic            in_range;
   logic            store_req;
   logic            item_ok;
   logic            req_fire;
   logic            seq_ready;
   logic [7:0]      rd_data;
   item_type        item;

   assign req_ch.ready = seq_ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Read index check against the current line length.
   assign idx_ext  = CMPW'(req_ch.read_index);
   assign in_range = idx_ext < CMPW'(fill_ff);

   // Decode the request into responses and the next editor state.
   always_comb begin
      item       = '0;
      item_ok    = 1'b0;
      fill_in    = fill_ff;
      pending_in = pending_ff;
      store_req  = 1'b0;
      item.tx0   = req_ch.rx_byte;
      case (req_ch.kind)
         KIND_RX: begin
            if (!pending_ff) begin
               item_ok = 1'b1;
               if (req_ch.rx_byte == CH_CR) begin
                  item.tx1      = CH_CR;
                  item.tx2      = CH_LF;
                  item.last_idx = 2'd2;
                  pending_in    = 1'b1;
               end else if (req_ch.rx_byte == CH_BS) begin
                  if (fill_ff != '0) begin
                     fill_in       = fill_ff - CW'(1);
                     item.tx1      = CH_SP;
                     item.tx2      = CH_BS;
                     item.last_idx = 2'd2;
                  end else begin
                     item.tx1      = CH_BEL;
                     item.last_idx = 2'd1;
                  end
               end else if (fill_ff < FILL_MAX) begin
                  store_req     = 1'b1;
                  fill_in       = fill_ff + CW'(1);
                  item.last_idx = 2'd0;
               end else begin
                  item.tx1      = CH_BEL;
                  item.last_idx = 2'd1;
               end
            end
         end
         KIND_TAKE: begin
            if (pending_ff) begin
               item_ok       = 1'b1;
               fill_in       = '0;
               pending_in    = 1'b0;
               item.tx0      = CH_CR;
               item.tx1      = CH_GT;
               item.tx2      = CH_SP;
               item.last_idx = 2'd2;
            end
         end
         KIND_READ: begin
            item_ok       = 1'b1;
            item.is_read  = 1'b1;
            item.in_range = in_range;
            item.tx0      = 8'h00;
            item.last_idx = 2'd0;
         end
         default: begin
            item_ok = 1'b0;
         end
      endcase
      fill_ext         = CMPW'(fill_in);
      item.line_length = fill_ext[5:0];
      item.line_ready  = pending_in;
   end

   // Editor state registers, updated on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         pending_ff <= 1'b0;
      end else if (req_fire) begin
         fill_ff    <= fill_in;
         pending_ff <= pending_in;
      end
   end

   // Line store: write at the fill position, read at the requested index.
   sle_line_store #(
      .DEPTH (BUFFER_DEPTH - 1),
      .AW    (CW)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_fire && store_req),
      .wr_addr (fill_ff),
      .wr_data (req_ch.rx_byte),
      .rd_en   (req_fire && (req_ch.kind == KIND_READ) && in_range),
      .rd_addr (idx_ext[CW-1:0]),
      .rd_data (rd_data)
   );

   // Response sequencer.
   sle_rsp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_load  (req_fire && item_ok),
      .item       (item),
      .rd_data    (rd_data),
      .item_ready (seq_ready),
      .rsp_ch     (rsp_ch)
   );

   // The fill count never exceeds the line capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count beyond line capacity");

   // While a command is pending only a take request may change the line.
   a_pending_hold: assert property (@(posedge clock) disable iff (reset)
      pending_ff && !(req_fire && req_ch.kind == KIND_TAKE) |=> $stable(fill_ff))
      else $error("line changed while command pending");

   // Taking a pending command clears the line and releases it.
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.kind == KIND_TAKE && pending_ff |=> fill_ff == '0 && !pending_ff)
      else $error("take did not clear the line");

endmodule

`default_nettype wire

// ===== design/sle_line_store.sv =====
// ----------------------------------------------------------------------------
// Serial line editor line store
// Single write port, single read port character memory with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_line_store
   import sle_pkg::*;
#(
   parameter int DEPTH = BUFFER_DEPTH_DEF - 1,
   parameter int AW    = $clog2(BUFFER_DEPTH_DEF)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sle_rsp_seq.sv =====
// ----------------------------------------------------------------------------
// Serial line editor response sequencer
// Holds one decoded request and plays out its responses one per cycle into
// a registered output stage while the response channel is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_rsp_seq
   import sle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_load,
   input  wire item_type   item,
   input  wire logic [7:0] rd_data,
   output logic            item_ready,
   sle_rsp_if.source       rsp_ch
);

   logic       a_valid_ff, a_valid_in;
   logic [1:0] a_idx_ff, a_idx_in;
   item_type   a_item_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_kind_ff;
   logic [7:0] rsp_tx_ff;
   logic [7:0] rsp_char_ff;
   logic [5:0] rsp_len_ff;
   logic       rsp_ready_ff;
   logic       rsp_last_ff;

   logic       out_load;
   logic       a_last;
   logic [7:0] tx_sel;

   // Move one response into the output stage when it is free or draining.
   assign out_load   = a_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign a_last     = (a_idx_ff == a_item_ff.last_idx);
   assign item_ready = !a_valid_ff || (out_load && a_last);

   // Pick the transmit byte for the current response.
   always_comb begin
      case (a_idx_ff)
         2'd0:    tx_sel = a_item_ff.tx0;
         2'd1:    tx_sel = a_item_ff.tx1;
         default: tx_sel = a_item_ff.tx2;
      endcase
   end

   // Next state of the holding stage.
   always_comb begin
      a_valid_in = a_valid_ff;
      a_idx_in   = a_idx_ff;
      if (item_load) begin
         a_valid_in = 1'b1;
         a_idx_in   = 2'd0;
      end else if (out_load) begin
         a_idx_in = a_idx_ff + 2'd1;
         if (a_last) begin
            a_valid_in = 1'b0;
         end
      end
   end

   // Next state of the output valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         a_idx_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         a_idx_ff     <= a_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (item_load) begin
         a_item_ff <= item;
      end
      if (out_load) begin
         rsp_len_ff   <= a_item_ff.line_length;
         rsp_ready_ff <= a_item_ff.line_ready;
         rsp_last_ff  <= a_last;
         if (a_item_ff.is_read) begin
            rsp_kind_ff <= RES_READ;
            rsp_tx_ff   <= 8'h00;
            rsp_char_ff <= a_item_ff.in_range ? rd_data : 8'h00;
         end else begin
            rsp_kind_ff <= RES_TX;
            rsp_tx_ff   <= tx_sel;
            rsp_char_ff <= 8'h00;
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;
   assign rsp_ch.tx_byte     = rsp_tx_ff;
   assign rsp_ch.read_char   = rsp_char_ff;
   assign rsp_ch.line_length = rsp_len_ff;
   assign rsp_ch.line_ready  = rsp_ready_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // The response index never runs past the last response of the request.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> a_idx_ff <= a_item_ff.last_idx)
      else $error("response index past last response");

   // A read request produces exactly one response.
   a_read_single: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_item_ff.is_read |-> a_item_ff.last_idx == 2'd0)
      else $error("read request with more than one response");

   // A new request is only taken when the held one is done or finishing.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      item_load && a_valid_ff |-> out_load && a_last)
      else $error("held request overwritten");

endmodule

`default_nettype wire
